### design/rrst_pkg.sv
package rrst_pkg;

    localparam int WINDOW_MAX = 256;

    localparam int SEQ_W      = 32;
    localparam int CFG_W      = 9;
    localparam int BUF_CNT_W  = 9;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam int SLOT_W     = $clog2(WINDOW_MAX);
    localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W      = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

    localparam int SCAN_W     = (WINDOW_MAX < 32) ? WINDOW_MAX : 32;
    localparam int SCAN_SH    = $clog2(SCAN_W);
    localparam int NUM_WORDS  = WINDOW_MAX / SCAN_W;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int STEP_W     = $clog2(NUM_WORDS + 1);

    localparam int ALU_W      = SEQ_W + 2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_MAXBUF = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WINDOW = CFG_W'(256);
    localparam logic [CFG_W-1:0] RESET_MAXBUF = CFG_W'(256);

    typedef enum logic [2:0] {
        ST_DUP       = 3'd0,
        ST_IN_ORDER  = 3'd1,
        ST_STORED    = 3'd2,
        ST_ALREADY   = 3'd3,
        ST_OUTSIDE   = 3'd4,
        ST_FULL      = 3'd5,
        ST_ACK_BUILT = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ACK_NONE      = 2'd0,
        ACK_DEFERRED  = 2'd1,
        ACK_IMMEDIATE = 2'd2
    } t_ack_mode;

endpackage

### design/receive_reorder_sack_tracker_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_kind, i_seq_num
// out       output     o_out_valid / i_out_ready  o_status, o_ack_mode, o_cumulative_ack,
//                                                 o_selective_ack, o_gap_nack, o_buffered_count
// cfg       input      psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// Every wide compare, increment and sum goes through one shared 34-bit adder, used once per
// step, and the held map is scanned one 32-bit word per cycle for the lowest held number.
// An in-order arrival also drains every held number directly behind it.
// Reset is synchronous; it clears the held map, the held count and the output valid flag
// at once and loads the configuration registers with their reset values.
// A result waits in the output register while the next request is accepted; a stalled
// output holds the sequencer in its last step.
module receive_reorder_sack_tracker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [rrst_pkg::SEQ_W-1:0]     i_seq_num,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_status,
    output logic [1:0]                    o_ack_mode,
    output logic [rrst_pkg::SEQ_W-1:0]     o_cumulative_ack,
    output logic [rrst_pkg::SEQ_W-1:0]     o_selective_ack,
    output logic [rrst_pkg::SEQ_W-1:0]     o_gap_nack,
    output logic [rrst_pkg::BUF_CNT_W-1:0] o_buffered_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrst_pkg::ADDR_W-1:0]    paddr,
    input  logic [rrst_pkg::DATA_W-1:0]    pwdata,
    output logic [rrst_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import rrst_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LOW   = 11'b000_0000_0010,
        S_END   = 11'b000_0000_0100,
        S_WIN   = 11'b000_0000_1000,
        S_HIGH  = 11'b000_0001_0000,
        S_INC   = 11'b000_0010_0000,
        S_DRAIN = 11'b000_0100_0000,
        S_GAP   = 11'b000_1000_0000,
        S_CUM   = 11'b001_0000_0000,
        S_SCAN  = 11'b010_0000_0000,
        S_SEL   = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [SEQ_W-1:0]      r_ne, n_ne;
    logic [SEQ_W-1:0]      r_hs, n_hs;
    logic [WINDOW_MAX-1:0] r_bitmap, n_bitmap;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [CFG_W-1:0]      r_win_cfg, n_win_cfg;
    logic [CFG_W-1:0]      r_maxbuf_cfg, n_maxbuf_cfg;
    logic                  r_out_valid, n_out_valid;

    logic [SEQ_W-1:0]      r_seq, n_seq;
    logic [SEQ_W:0]        r_acc, n_acc;
    logic                  r_eq, n_eq;
    logic                  r_use_gap, n_use_gap;
    logic                  r_gap, n_gap;
    t_status               r_status, n_status;
    t_ack_mode             r_mode, n_mode;
    logic [SEQ_W-1:0]      r_cum, n_cum;
    logic [WORD_IDX_W-1:0] r_scan_word, n_scan_word;
    logic [STEP_W-1:0]     r_scan_step, n_scan_step;
    logic                  r_found, n_found;
    logic [SLOT_W-1:0]     r_k, n_k;

    t_status               r_o_status, n_o_status;
    t_ack_mode             r_o_mode, n_o_mode;
    logic [SEQ_W-1:0]      r_o_cum, n_o_cum;
    logic [SEQ_W-1:0]      r_o_sel, n_o_sel;
    logic [SEQ_W-1:0]      r_o_gap, n_o_gap;
    logic [BUF_CNT_W-1:0]  r_o_count, n_o_count;

    logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
    logic                  alu_sub;
    logic                  alu_borrow;
    logic [SEQ_W:0]        eff_win;
    logic [SLOT_W-1:0]     slot_seq, slot_ne;
    logic [SCAN_SH-1:0]    bit_ne;
    logic [SCAN_W-1:0]     scan_bits, scan_mask, scan_masked;
    logic [SCAN_SH-1:0]    scan_pos;
    logic                  scan_hit;
    logic                  out_free;
    logic                  cfg_write;

    assign slot_seq  = r_seq[SLOT_W-1:0];
    assign slot_ne   = r_ne[SLOT_W-1:0];
    assign bit_ne    = slot_ne[SCAN_SH-1:0];
    assign out_free  = !r_out_valid || i_out_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        if (r_win_cfg == '0) begin
            eff_win = (SEQ_W + 1)'(1);
        end else if ((SEQ_W + 1)'(r_win_cfg) > (SEQ_W + 1)'(WINDOW_MAX)) begin
            eff_win = (SEQ_W + 1)'(WINDOW_MAX);
        end else begin
            eff_win = (SEQ_W + 1)'(r_win_cfg);
        end
    end

    // The shared adder serves every wide compare, increment and sum of the sequencer.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_LOW: begin
                alu_a   = ALU_W'(r_seq);
                alu_b   = ALU_W'(r_ne);
                alu_sub = 1'b1;
            end
            S_END: begin
                alu_a = ALU_W'(r_ne);
                alu_b = ALU_W'(eff_win);
            end
            S_WIN: begin
                alu_a   = ALU_W'(r_seq);
                alu_b   = ALU_W'(r_acc);
                alu_sub = 1'b1;
            end
            S_HIGH: begin
                alu_a   = ALU_W'(r_hs);
                alu_b   = ALU_W'(r_seq);
                alu_sub = 1'b1;
            end
            S_INC: begin
                alu_a = ALU_W'(r_ne);
                alu_b = ALU_W'(1);
            end
            S_GAP: begin
                alu_a   = ALU_W'(r_hs);
                alu_b   = ALU_W'(r_ne);
                alu_sub = 1'b1;
            end
            S_CUM: begin
                alu_a   = ALU_W'(r_ne);
                alu_b   = ALU_W'(1);
                alu_sub = 1'b1;
            end
            S_SEL: begin
                alu_a = ALU_W'(r_ne);
                alu_b = ALU_W'(r_k);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res    = alu_sub ? (alu_a + ~alu_b + ALU_W'(1)) : (alu_a + alu_b);
    assign alu_borrow = alu_res[ALU_W-1];

    assign scan_bits = r_bitmap[(SLOT_W'(r_scan_word) << SCAN_SH) +: SCAN_W];

    // The first visit of the start word looks above the expected slot, the last one below.
    always_comb begin
        for (int i = 0; i < SCAN_W; i++) begin
            if (r_scan_step == '0) begin
                scan_mask[i] = SCAN_SH'(i) > bit_ne;
            end else if (r_scan_step == STEP_W'(NUM_WORDS)) begin
                scan_mask[i] = SCAN_SH'(i) < bit_ne;
            end else begin
                scan_mask[i] = 1'b1;
            end
        end
    end

    assign scan_masked = scan_bits & scan_mask;

    always_comb begin
        scan_hit = 1'b0;
        scan_pos = '0;
        for (int i = SCAN_W - 1; i >= 0; i--) begin
            if (scan_masked[i]) begin
                scan_hit = 1'b1;
                scan_pos = SCAN_SH'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ne         = r_ne;
        n_hs         = r_hs;
        n_bitmap     = r_bitmap;
        n_count      = r_count;
        n_win_cfg    = r_win_cfg;
        n_maxbuf_cfg = r_maxbuf_cfg;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_seq        = r_seq;
        n_acc        = r_acc;
        n_eq         = r_eq;
        n_use_gap    = r_use_gap;
        n_gap        = r_gap;
        n_status     = r_status;
        n_mode       = r_mode;
        n_cum        = r_cum;
        n_scan_word  = r_scan_word;
        n_scan_step  = r_scan_step;
        n_found      = r_found;
        n_k          = r_k;
        n_o_status   = r_o_status;
        n_o_mode     = r_o_mode;
        n_o_cum      = r_o_cum;
        n_o_sel      = r_o_sel;
        n_o_gap      = r_o_gap;
        n_o_count    = r_o_count;

        if (cfg_write) begin
            if (paddr[2] == REG_MAXBUF) begin
                n_maxbuf_cfg = pwdata[CFG_W-1:0];
            end else begin
                n_win_cfg = pwdata[CFG_W-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_seq = i_seq_num;
                    if (i_kind == KIND_ACK) begin
                        n_status  = ST_ACK_BUILT;
                        n_mode    = ACK_NONE;
                        n_use_gap = 1'b0;
                        n_state   = S_GAP;
                    end else begin
                        n_state = S_LOW;
                    end
                end
            end
            S_LOW: begin
                n_eq = (alu_res == '0);
                if (alu_borrow) begin
                    n_status  = ST_DUP;
                    n_mode    = ACK_DEFERRED;
                    n_use_gap = 1'b0;
                    n_state   = S_GAP;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                n_acc   = alu_res[SEQ_W:0];
                n_state = S_WIN;
            end
            S_WIN: begin
                if (!alu_borrow) begin
                    n_status  = ST_OUTSIDE;
                    n_mode    = ACK_NONE;
                    n_use_gap = 1'b0;
                    n_state   = S_GAP;
                end else begin
                    n_state = S_HIGH;
                end
            end
            S_HIGH: begin
                if (alu_borrow) begin
                    n_hs = r_seq;
                end
                priority if (r_eq) begin
                    n_status  = ST_IN_ORDER;
                    n_use_gap = 1'b1;
                    n_state   = S_INC;
                end else if (CMP_W'(r_count) >= CMP_W'(r_maxbuf_cfg)) begin
                    n_status  = ST_FULL;
                    n_mode    = ACK_NONE;
                    n_use_gap = 1'b0;
                    n_state   = S_GAP;
                end else if (r_bitmap[slot_seq]) begin
                    n_status  = ST_ALREADY;
                    n_use_gap = 1'b1;
                    n_state   = S_GAP;
                end else begin
                    n_bitmap[slot_seq] = 1'b1;
                    n_count            = r_count + COUNT_W'(1);
                    n_status           = ST_STORED;
                    n_use_gap          = 1'b1;
                    n_state            = S_GAP;
                end
            end
            S_INC: begin
                n_ne    = alu_res[SEQ_W-1:0];
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (r_count != '0 && r_bitmap[slot_ne]) begin
                    n_bitmap[slot_ne] = 1'b0;
                    n_count           = r_count - COUNT_W'(1);
                    n_state           = S_INC;
                end else begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                n_gap = !alu_borrow && (r_count != '0);
                if (r_use_gap) begin
                    n_mode = n_gap ? ACK_IMMEDIATE : ACK_DEFERRED;
                end
                n_state = S_CUM;
            end
            S_CUM: begin
                n_cum       = alu_borrow ? '0 : alu_res[SEQ_W-1:0];
                n_scan_word = WORD_IDX_W'(slot_ne >> SCAN_SH);
                n_scan_step = '0;
                n_found     = 1'b0;
                n_k         = '0;
                n_state     = (r_count != '0) ? S_SCAN : S_SEL;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_found = 1'b1;
                    n_k     = ((SLOT_W'(r_scan_word) << SCAN_SH) | SLOT_W'(scan_pos)) - slot_ne;
                    n_state = S_SEL;
                end else if (r_scan_step == STEP_W'(NUM_WORDS)) begin
                    n_state = S_SEL;
                end else begin
                    n_scan_step = r_scan_step + STEP_W'(1);
                    n_scan_word = (r_scan_word == WORD_IDX_W'(NUM_WORDS - 1)) ?
                                  '0 : r_scan_word + WORD_IDX_W'(1);
                end
            end
            S_SEL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_mode    = r_mode;
                    n_o_cum     = r_cum;
                    n_o_sel     = r_found ? alu_res[SEQ_W-1:0] : '0;
                    n_o_gap     = r_gap ? r_ne : '0;
                    n_o_count   = BUF_CNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ne         <= SEQ_W'(1);
            r_hs         <= '0;
            r_bitmap     <= '0;
            r_count      <= '0;
            r_win_cfg    <= RESET_WINDOW;
            r_maxbuf_cfg <= RESET_MAXBUF;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ne         <= n_ne;
            r_hs         <= n_hs;
            r_bitmap     <= n_bitmap;
            r_count      <= n_count;
            r_win_cfg    <= n_win_cfg;
            r_maxbuf_cfg <= n_maxbuf_cfg;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq       <= n_seq;
        r_acc       <= n_acc;
        r_eq        <= n_eq;
        r_use_gap   <= n_use_gap;
        r_gap       <= n_gap;
        r_status    <= n_status;
        r_mode      <= n_mode;
        r_cum       <= n_cum;
        r_scan_word <= n_scan_word;
        r_scan_step <= n_scan_step;
        r_found     <= n_found;
        r_k         <= n_k;
        r_o_status  <= n_o_status;
        r_o_mode    <= n_o_mode;
        r_o_cum     <= n_o_cum;
        r_o_sel     <= n_o_sel;
        r_o_gap     <= n_o_gap;
        r_o_count   <= n_o_count;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_ack_mode       = r_o_mode;
    assign o_cumulative_ack = r_o_cum;
    assign o_selective_ack  = r_o_sel;
    assign o_gap_nack       = r_o_gap;
    assign o_buffered_count = r_o_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAXBUF) ? DATA_W'(r_maxbuf_cfg) : DATA_W'(r_win_cfg);

endmodule

### design/rrst_checker.sv
module rrst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [2:0]                    o_status,
    input logic [1:0]                    o_ack_mode,
    input logic [rrst_pkg::SEQ_W-1:0]     o_cumulative_ack,
    input logic [rrst_pkg::SEQ_W-1:0]     o_selective_ack,
    input logic [rrst_pkg::SEQ_W-1:0]     o_gap_nack,
    input logic [rrst_pkg::BUF_CNT_W-1:0] o_buffered_count
);
    import rrst_pkg::*;

    // A reported gap is always the number just above the cumulative ack.
    a_gap_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gap_nack != '0) |->
        (o_gap_nack == o_cumulative_ack + SEQ_W'(1)))
        else $error("gap nack does not follow cumulative ack");

    // Out-of-window drops, full drops and ack requests never ask for an ack.
    a_no_ack_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_ACK_BUILT || o_status == ST_OUTSIDE ||
                         o_status == ST_FULL)) |->
        (o_ack_mode == ACK_NONE))
        else $error("ack mode set on a drop or an ack request");

    // With nothing held there is neither a selective ack nor a gap.
    a_empty_sack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_buffered_count == '0) |->
        (o_selective_ack == '0 && o_gap_nack == '0))
        else $error("selective ack or gap reported with nothing held");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_status) && $stable(o_selective_ack) &&
         $stable(o_cumulative_ack)))
        else $error("stalled result changed or dropped");

endmodule

bind receive_reorder_sack_tracker_unit rrst_checker u_rrst_checker (.*);
